[design/jpeg_huffman_decoder_defines.svh]
// Assertion macros shared by the JPEG Huffman decoder checkers.
`ifndef JPEG_HUFFMAN_DECODER_DEFINES_SVH
`define JPEG_HUFFMAN_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JHD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jpeg_huffman_decoder check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jpeg_huffman_decoder check failed");

`endif

[design/jhd_pkg.sv]
// Shared constants, types and the command and status structs of the JPEG Huffman decoder.
package jhd_pkg;

    localparam int MAX_CODE_LENGTH   = 16;
    localparam int VALUE_TABLE_DEPTH = 256;

    localparam int FUNC_W    = 2;
    localparam int SLOT_W    = 4;
    localparam int LEN_SLOTS = 16;
    localparam int BYTE_W    = 8;
    localparam int CODE_W    = 16;
    localparam int BOUND_W   = 17;
    localparam int LEN_W     = 5;
    localparam int RIDX_W    = 9;
    localparam int VT_AW     = $clog2(VALUE_TABLE_DEPTH);
    localparam int BIT_IDX_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_VALUE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BIT   = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_FLUSH = 4'b1000
    } jhd_state_t;

    typedef struct packed {
        logic load_count;
        logic load_value;
        logic load_byte;
        logic apply_bit;
        logic capture_sym;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic result;
        logic match;
        logic hold_valid;
        logic out_free;
        logic byte_done;
    } dp_status_t;

endpackage

[design/jpeg_huffman_decoder.sv]
// Top level of the JPEG canonical Huffman decoder.
// Count loads (func 0) and symbol value loads (func 1) give no transaction on the output.
// A data byte (func 2) is decoded one bit per cycle unless a held result waits on a stalled
// output, each bit compared against one past the greatest code of its length. After the
// accepting cycle the input stays stalled through the bit steps, a fetch step for each
// matched symbol for the registered read of the 256-entry value table, and a closing step;
// stalls on the output add to that. One result is held back until the next one appears or
// the byte ends, which is how the final result of a byte gets its last flag. There is no
// clearing pass after reset: tables must be loaded before decoding.
module jpeg_huffman_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [jhd_pkg::FUNC_W-1:0] func,
    input  logic [jhd_pkg::SLOT_W-1:0] length_slot,
    input  logic [7:0]                 code_count,
    input  logic [7:0]                 value_slot,
    input  logic [7:0]                 symbol_value,
    input  logic [7:0]                 data_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 symbol,
    output logic                       decode_error,
    output logic                       last
);
    import jhd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    jhd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    jhd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .length_slot  (length_slot),
        .code_count   (code_count),
        .value_slot   (value_slot),
        .symbol_value (symbol_value),
        .data_byte    (data_byte),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .symbol       (symbol),
        .decode_error (decode_error),
        .last         (last)
    );

endmodule

[design/jhd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module jhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/jhd_ctrl.sv]
// Sequencing state machine of the JPEG Huffman decoder.
module jhd_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [jhd_pkg::FUNC_W-1:0] func,
    input  jhd_pkg::dp_status_t        status,
    output jhd_pkg::dp_cmd_t           cmd,
    output logic                       in_stall
);
    import jhd_pkg::*;

    jhd_state_t state_reg;
    jhd_state_t state_next;
    logic       blocked;

    // A new result may not overwrite a held one until the output register can take it.
    assign blocked = status.result && status.hold_valid && !status.out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_count = (func == FUNC_COUNT);
                    cmd.load_value = (func == FUNC_VALUE);
                    cmd.load_byte  = (func == FUNC_DATA);
                    if (func == FUNC_DATA)
                    begin
                        state_next = ST_BIT;
                    end
                end
            end
            ST_BIT:
            begin
                if (!blocked)
                begin
                    cmd.apply_bit = 1'b1;
                    if (status.match)
                    begin
                        state_next = ST_FETCH;
                    end
                    else if (status.byte_done)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.capture_sym = 1'b1;
                state_next      = status.byte_done ? ST_FLUSH : ST_BIT;
            end
            ST_FLUSH:
            begin
                if (!status.hold_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

[design/jhd_datapath.sv]
// Code tables, bit shifter, match logic and result registers of the decoder.
module jhd_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  jhd_pkg::dp_cmd_t           cmd,
    output jhd_pkg::dp_status_t        status,
    input  logic [jhd_pkg::SLOT_W-1:0] length_slot,
    input  logic [7:0]                 code_count,
    input  logic [7:0]                 value_slot,
    input  logic [7:0]                 symbol_value,
    input  logic [7:0]                 data_byte,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [7:0]                 symbol,
    output logic                       decode_error,
    output logic                       last
);
    import jhd_pkg::*;

    // Per-length tables: each is written at one slot and read at one slot.
    logic [BOUND_W-1:0] greatest_reg [LEN_SLOTS];
    logic [CODE_W-1:0]  least_reg    [LEN_SLOTS];
    logic [7:0]         first_idx_reg [LEN_SLOTS];

    logic [BOUND_W-1:0] run_code_reg;
    logic [RIDX_W-1:0]  run_index_reg;
    logic [CODE_W-1:0]  partial_code_reg;
    logic [LEN_W-1:0]   partial_len_reg;
    logic [BYTE_W-1:0]  shift_reg;
    logic [BIT_IDX_W-1:0] bit_idx_reg;

    logic               hold_valid_reg;
    logic [7:0]         hold_sym_reg;
    logic               hold_err_reg;
    logic               fetch_oob_reg;

    logic               out_valid_reg;
    logic [7:0]         out_sym_reg;
    logic               out_err_reg;
    logic               out_last_reg;

    logic               count_ok;
    logic [BOUND_W-1:0] base_code;
    logic [RIDX_W-1:0]  base_index;
    logic [BOUND_W-1:0] bound;
    logic [CODE_W-1:0]  code_new;
    logic [LEN_W-1:0]   len_new;
    logic [SLOT_W-1:0]  slot;
    logic               match;
    logic               no_match_err;
    logic [7:0]         val_idx;
    logic               idx_oob;
    logic               value_we;
    logic [7:0]         ram_rdata;
    logic               out_free;
    logic               push_prev;

    // Count loads: slot zero restarts the canonical code sequence.
    assign count_ok   = ({1'b0, length_slot} < LEN_W'(MAX_CODE_LENGTH));
    assign base_code  = (length_slot == '0) ? '0 : run_code_reg;
    assign base_index = (length_slot == '0) ? '0 : run_index_reg;
    assign bound      = base_code + BOUND_W'(code_count);

    // One bit of the stream against the bound of the current length.
    assign code_new     = {partial_code_reg[CODE_W-2:0], shift_reg[BYTE_W-1]};
    assign len_new      = partial_len_reg + LEN_W'(1);
    assign slot         = partial_len_reg[SLOT_W-1:0];
    assign match        = ({1'b0, code_new} < greatest_reg[slot]);
    assign no_match_err = !match && (len_new >= LEN_W'(MAX_CODE_LENGTH));
    assign val_idx      = first_idx_reg[slot] + code_new[7:0] - least_reg[slot][7:0];
    assign idx_oob      = ({1'b0, val_idx} >= 9'(VALUE_TABLE_DEPTH));

    assign value_we = cmd.load_value && ({1'b0, value_slot} < 9'(VALUE_TABLE_DEPTH));

    jhd_ram #(
        .WIDTH (8),
        .DEPTH (VALUE_TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (value_we),
        .waddr (value_slot[VT_AW-1:0]),
        .wdata (symbol_value),
        .raddr (val_idx[VT_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign push_prev = cmd.apply_bit && (match || no_match_err) && hold_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_count && count_ok)
        begin
            least_reg[length_slot]     <= base_code[CODE_W-1:0];
            greatest_reg[length_slot]  <= bound;
            first_idx_reg[length_slot] <= base_index[7:0];
        end
        if (cmd.load_byte)
        begin
            shift_reg <= data_byte;
        end
        else if (cmd.apply_bit)
        begin
            shift_reg <= {shift_reg[BYTE_W-2:0], 1'b0};
        end
        if (cmd.apply_bit && match)
        begin
            fetch_oob_reg <= idx_oob;
        end
        if (cmd.apply_bit && no_match_err)
        begin
            hold_sym_reg <= '0;
            hold_err_reg <= 1'b1;
        end
        else if (cmd.capture_sym)
        begin
            hold_sym_reg <= fetch_oob_reg ? '0 : ram_rdata;
            hold_err_reg <= 1'b0;
        end
        if (push_prev || cmd.flush)
        begin
            out_sym_reg  <= hold_sym_reg;
            out_err_reg  <= hold_err_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_code_reg     <= '0;
            run_index_reg    <= '0;
            partial_code_reg <= '0;
            partial_len_reg  <= '0;
            bit_idx_reg      <= '0;
            hold_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_count && count_ok)
            begin
                run_code_reg  <= {bound[BOUND_W-2:0], 1'b0};
                run_index_reg <= base_index + RIDX_W'(code_count);
            end
            if (cmd.load_byte)
            begin
                bit_idx_reg <= '0;
            end
            else if (cmd.apply_bit)
            begin
                bit_idx_reg <= bit_idx_reg + BIT_IDX_W'(1);
                if (match || no_match_err)
                begin
                    partial_code_reg <= '0;
                    partial_len_reg  <= '0;
                end
                else
                begin
                    partial_code_reg <= code_new;
                    partial_len_reg  <= len_new;
                end
            end
            if (cmd.apply_bit && no_match_err)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if ((cmd.apply_bit && match) || cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (cmd.capture_sym)
            begin
                hold_valid_reg <= 1'b1;
            end
            if (push_prev || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.result     = match || no_match_err;
    assign status.match      = match;
    assign status.hold_valid = hold_valid_reg;
    assign status.out_free   = out_free;
    // During a bit this flags the last bit; after it, a wrapped index means the byte is used up.
    assign status.byte_done  = cmd.capture_sym ? (bit_idx_reg == '0)
                                               : (bit_idx_reg == BIT_IDX_W'(BYTE_W - 1));

    assign out_valid    = out_valid_reg;
    assign symbol       = out_sym_reg;
    assign decode_error = out_err_reg;
    assign last         = out_last_reg;

endmodule

[design/jhd_checker.sv]
// Port-level checker for the JPEG Huffman decoder, bound to the top level.
`include "jpeg_huffman_decoder_defines.svh"

module jhd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [jhd_pkg::FUNC_W-1:0] func,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [7:0]                 symbol,
    input logic                       decode_error,
    input logic                       last
);
    import jhd_pkg::*;

    // A stalled output transaction stays up and unchanged.
    `JHD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(symbol) && $stable(decode_error) && $stable(last))

    // An error result never carries a symbol.
    `JHD_ASSERT_NOW(a_err_sym, out_valid && decode_error, symbol == 8'd0)

    // An accepted data byte occupies the decoder on the next cycle.
    `JHD_ASSERT_NEXT(a_byte_busy, in_valid && !in_stall && func == FUNC_DATA, in_stall)

    // Table loads and unused codes finish in the cycle they are accepted.
    `JHD_ASSERT_NEXT(a_load_free, in_valid && !in_stall && func != FUNC_DATA, !in_stall)

endmodule

bind jpeg_huffman_decoder jhd_checker u_jhd_checker (.*);

[tb/sv/jpeg_huffman_decoder_tb.sv]
// Self-checking testbench for the JPEG canonical Huffman decoder, with a symbol tracker class.
`timescale 1ns / 100ps

module jpeg_huffman_decoder_tb;
    import jhd_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [7:0] sym;
        logic       err;
        logic       fin;
    } decoded_t;

    // Tracks the code tables and the bit accumulator, and holds the symbols still due.
    class canon_decoder;
        logic [BOUND_W-1:0] bound_tab [LEN_SLOTS];
        logic [CODE_W-1:0]  base_tab  [LEN_SLOTS];
        logic [7:0]         start_tab [LEN_SLOTS];
        logic [7:0]         sym_tab   [VALUE_TABLE_DEPTH];
        bit                 sym_set   [VALUE_TABLE_DEPTH];
        logic [BOUND_W-1:0] next_code;
        logic [RIDX_W-1:0]  next_index;
        logic [CODE_W-1:0]  code_acc;
        logic [LEN_W-1:0]   code_len;
        decoded_t           due_symbols[$];
        int                 bad_fields;
        int                 symbols_seen;
        int                 errors_seen;

        function new();
            next_code    = '0;
            next_index   = '0;
            code_acc     = '0;
            code_len     = '0;
            bad_fields   = 0;
            symbols_seen = 0;
            errors_seen  = 0;
        endfunction

        function void take_item(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] slot,
                                logic [7:0] count, logic [7:0] vslot, logic [7:0] sval,
                                logic [7:0] dbyte);
            logic [BOUND_W-1:0] bound;
            logic [3:0]         lslot;
            logic [15:0]        offs;
            decoded_t           burst [8];
            int                 n;
            int                 b;
            n = 0;
            if (f == FUNC_COUNT)
            begin
                if (slot < MAX_CODE_LENGTH)
                begin
                    if (slot == 0)
                    begin
                        next_code  = '0;
                        next_index = '0;
                    end
                    bound           = next_code + {9'd0, count};
                    base_tab[slot]  = next_code[CODE_W-1:0];
                    bound_tab[slot] = bound;
                    start_tab[slot] = next_index[7:0];
                    next_code       = {bound[BOUND_W-2:0], 1'b0};
                    next_index      = next_index + {1'b0, count};
                end
            end
            else if (f == FUNC_VALUE)
            begin
                if (vslot < VALUE_TABLE_DEPTH)
                begin
                    sym_tab[vslot] = sval;
                    sym_set[vslot] = 1'b1;
                end
            end
            else if (f == FUNC_DATA)
            begin
                for (b = 7; b >= 0; b--)
                begin
                    code_acc = {code_acc[CODE_W-2:0], dbyte[b]};
                    code_len = code_len + 1'b1;
                    lslot    = code_len[3:0] - 4'd1;
                    if ({1'b0, code_acc} < bound_tab[lslot])
                    begin
                        offs = {8'd0, start_tab[lslot]} + code_acc - base_tab[lslot];
                        burst[n].sym = (offs[7:0] < VALUE_TABLE_DEPTH) ?
                                       sym_tab[offs[7:0]] : 8'd0;
                        burst[n].err = 1'b0;
                        burst[n].fin = 1'b0;
                        n++;
                        code_acc = '0;
                        code_len = '0;
                    end
                    else if (code_len >= MAX_CODE_LENGTH)
                    begin
                        burst[n].sym = 8'd0;
                        burst[n].err = 1'b1;
                        burst[n].fin = 1'b0;
                        n++;
                        code_acc = '0;
                        code_len = '0;
                    end
                end
                if (n > 0)
                    burst[n-1].fin = 1'b1;
                for (b = 0; b < n; b++)
                    due_symbols.insert(due_symbols.size(), burst[b]);
            end
        endfunction

        // Returns the first symbol entry that this byte would read before it is written,
        // or -1 when every symbol it decodes is already loaded.
        function int first_gap(logic [7:0] dbyte);
            logic [CODE_W-1:0] acc;
            logic [LEN_W-1:0]  len;
            logic [3:0]        lslot;
            logic [15:0]       offs;
            int                b;
            acc = code_acc;
            len = code_len;
            for (b = 7; b >= 0; b--)
            begin
                acc   = {acc[CODE_W-2:0], dbyte[b]};
                len   = len + 1'b1;
                lslot = len[3:0] - 4'd1;
                if ({1'b0, acc} < bound_tab[lslot])
                begin
                    offs = {8'd0, start_tab[lslot]} + acc - base_tab[lslot];
                    if (!sym_set[offs[7:0]])
                        return int'(offs[7:0]);
                    acc = '0;
                    len = '0;
                end
                else if (len >= MAX_CODE_LENGTH)
                begin
                    acc = '0;
                    len = '0;
                end
            end
            return -1;
        endfunction

        function void match_output(logic [7:0] sym, logic err, logic fin);
            decoded_t want;
            if (due_symbols.size() == 0)
            begin
                $error("unexpected result: symbol %0h decode_error %0b last %0b", sym, err, fin);
                bad_fields++;
                return;
            end
            want = due_symbols.pop_front();
            if (sym !== want.sym)
            begin
                $error("symbol mismatch: expected %0h, actual %0h", want.sym, sym);
                bad_fields++;
            end
            if (err !== want.err)
            begin
                $error("decode_error mismatch: expected %0b, actual %0b", want.err, err);
                bad_fields++;
            end
            if (fin !== want.fin)
            begin
                $error("last mismatch: expected %0b, actual %0b", want.fin, fin);
                bad_fields++;
            end
            symbols_seen++;
            if (want.err)
                errors_seen++;
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [FUNC_W-1:0] func         = FUNC_COUNT;
    logic [SLOT_W-1:0] length_slot  = '0;
    logic [7:0]        code_count   = '0;
    logic [7:0]        value_slot   = '0;
    logic [7:0]        symbol_value = '0;
    logic [7:0]        data_byte    = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [7:0]        symbol;
    logic              decode_error;
    logic              last;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           items_sent    = 0;
    canon_decoder tracker;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    jpeg_huffman_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .length_slot  (length_slot),
        .code_count   (code_count),
        .value_slot   (value_slot),
        .symbol_value (symbol_value),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .decode_error (decode_error),
        .last         (last)
    );

    // Output side: check each accepted transaction, then pick the next stall value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_output(symbol, decode_error, last);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_item(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] slot, logic [7:0] count,
                             logic [7:0] vslot, logic [7:0] sval, logic [7:0] dbyte);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        func         <= f;
        length_slot  <= slot;
        code_count   <= count;
        value_slot   <= vslot;
        symbol_value <= sval;
        data_byte    <= dbyte;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_item(f, slot, count, vslot, sval, dbyte);
        items_sent++;
    endtask

    task automatic count_load(logic [SLOT_W-1:0] slot, logic [7:0] count);
        send_item(FUNC_COUNT, slot, count, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic value_load(logic [7:0] vslot, logic [7:0] sval);
        send_item(FUNC_VALUE, 4'($urandom), 8'($urandom), vslot, sval, 8'($urandom));
    endtask

    task automatic decode_byte(logic [7:0] dbyte);
        send_item(FUNC_DATA, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), dbyte);
    endtask

    task automatic spare_item();
        send_item(FUNC_SPARE, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // Decodes a random byte, or instead loads the first symbol entry it would read unwritten.
    task automatic random_decode();
        logic [7:0] dbyte;
        int         gap;
        dbyte = 8'($urandom);
        gap   = tracker.first_gap(dbyte);
        if (gap < 0)
            decode_byte(dbyte);
        else
            value_load(gap[7:0], 8'($urandom));
    endtask

    // Loads all sixteen counts of a valid prefix code. Most levels keep one code free,
    // so long bit runs down that branch still end in a decode error.
    task automatic load_canon_table();
        int used;
        int room;
        int lim;
        int cnt;
        int s;
        used = 0;
        for (s = 0; s < LEN_SLOTS; s++)
        begin
            room = (1 << (s + 1)) - used;
            if ($urandom_range(3) != 0 && room > 0)
                room = room - 1;
            lim = (room > 255) ? 255 : room;
            if (lim <= 0)
                cnt = 0;
            else if ($urandom_range(3) == 0)
                cnt = $urandom_range(lim);
            else
                cnt = $urandom_range((lim < 4) ? lim : 4);
            count_load(s[SLOT_W-1:0], cnt[7:0]);
            used = (used + cnt) * 2;
        end
    endtask

    initial
    begin
        int i;
        int phase;
        int pick;
        int target;
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first symbol entries are written up front; random decodes fill the rest
        // on demand, so no decode reads an empty entry.
        for (i = 0; i < 16; i++)
            value_load(i[7:0], (i == 1) ? 8'hFF : (i == 2) ? 8'h00 : 8'($urandom));

        // An empty code: sixteen bits give a decode error.
        for (i = 0; i < LEN_SLOTS; i++)
            count_load(i[SLOT_W-1:0], 8'd0);
        decode_byte(8'h00);
        decode_byte(8'hFF);
        spare_item();

        // Two one-bit codes: eight symbols per byte.
        count_load(4'd0, 8'd2);
        decode_byte(8'h00);
        decode_byte(8'hFF);
        decode_byte(8'h5A);

        // Full counts make the running code and index wrap.
        for (i = 0; i < 10; i++)
            count_load(i[SLOT_W-1:0], 8'hFF);
        count_load(4'd15, 8'hFF);
        decode_byte(8'hFF);
        decode_byte(8'h3C);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 33 : 0;
            load_canon_table();
            target = items_sent + 20;
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 3)
                    load_canon_table();
                else if (pick < 10)
                    count_load(4'($urandom), 8'($urandom));
                else if (pick < 20)
                    value_load(8'($urandom), 8'($urandom));
                else if (pick < 23)
                    spare_item();
                else
                    random_decode();
            end
        end
        in_valid <= 1'b0;

        while (tracker.due_symbols.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d input transactions and %0d decoded results (%0d decode errors),",
                 items_sent, tracker.symbols_seen, tracker.errors_seen);
        $display("over empty, one-bit, wrapping and random prefix tables under three stall mixes.");
        if (tracker.bad_fields == 0)
            $display("jpeg_huffman_decoder regression: pass");
        else
            $display("jpeg_huffman_decoder regression: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("jpeg_huffman_decoder regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/jhd_pkg.sv
design/jhd_ram.sv
design/jhd_ctrl.sv
design/jhd_datapath.sv
design/jpeg_huffman_decoder.sv
design/jhd_checker.sv
tb/sv/jpeg_huffman_decoder_tb.sv
